// ===== hw/rtl/cfp_pkg.sv =====
// Shared types, constants and helpers for the composite format parser.
// No dependencies; used by every module of the block.
`default_nettype none

package cfp_pkg;

   localparam int ARG_INDEX_BITS = 8;
   localparam int IDX_ACC_BITS   = ARG_INDEX_BITS + 4;
   localparam int CHAR_BITS      = 16;
   localparam int WIDTH_BITS     = 24;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = 2;
   localparam int FIFO_CNT_BITS  = 3;

   localparam logic [WIDTH_BITS-1:0] WIDTH_LIMIT = 24'd1000000;

   localparam logic [CHAR_BITS-1:0] CH_LBRACE = 16'h007B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE = 16'h007D;
   localparam logic [CHAR_BITS-1:0] CH_COMMA  = 16'h002C;
   localparam logic [CHAR_BITS-1:0] CH_MINUS  = 16'h002D;
   localparam logic [CHAR_BITS-1:0] CH_COLON  = 16'h003A;
   localparam logic [CHAR_BITS-1:0] CH_SPACE  = 16'h0020;
   localparam logic [CHAR_BITS-1:0] CH_ZERO   = 16'h0030;
   localparam logic [CHAR_BITS-1:0] CH_NINE   = 16'h0039;

   typedef enum logic [3:0] {
      S_LIT,
      S_LBRACE,
      S_RBRACE,
      S_INDEX,
      S_AFTER_INDEX,
      S_WIDTH_START,
      S_WIDTH_MINUS,
      S_WIDTH,
      S_AFTER_WIDTH,
      S_SPEC,
      S_SPEC_LBRACE,
      S_SPEC_RBRACE,
      S_ERROR
   } state_type;

   typedef enum logic [2:0] {
      K_LIT   = 3'd0,
      K_SPEC  = 3'd1,
      K_FIELD = 3'd2,
      K_DONE  = 3'd3,
      K_ERROR = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [CHAR_BITS-1:0]      char_out;
      logic [ARG_INDEX_BITS-1:0] arg_index;
      logic [WIDTH_BITS-1:0]     field_width;
      logic                      left_justify;
      logic                      last;
   } result_type;

   // results of one item: count (0..2) and up to two records
   typedef struct packed {
      logic [1:0] n;
      result_type r0;
      result_type r1;
   } step_type;

   function automatic result_type mk_char(input kind_type k, input logic [CHAR_BITS-1:0] ch);
      result_type r;
      r              = '0;
      r.kind         = k;
      r.char_out     = ch;
      return r;
   endfunction

   function automatic result_type mk_field(input logic [ARG_INDEX_BITS-1:0] idx,
                                           input logic [WIDTH_BITS-1:0] wid,
                                           input logic lj);
      result_type r;
      r              = '0;
      r.kind         = K_FIELD;
      r.arg_index    = idx;
      r.field_width  = wid;
      r.left_justify = lj;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfp_parse.sv =====
// Parser state machine: field accumulators and per-item result decode.
// Depends on cfp_pkg.
`default_nettype none

module cfp_parse (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire logic [cfp_pkg::CHAR_BITS-1:0]     code_unit,
   input  wire logic                              is_end,
   input  wire logic [cfp_pkg::ARG_INDEX_BITS-1:0] arg_count,
   output cfp_pkg::step_type                      step
);

   cfp_pkg::state_type                     st_ff, st_in;
   logic [cfp_pkg::ARG_INDEX_BITS-1:0]     idx_ff, idx_in;
   logic [cfp_pkg::WIDTH_BITS-1:0]         wid_ff, wid_in;
   logic                                   minus_ff, minus_in;

   logic                                   is_digit;
   logic [3:0]                             digit;
   logic [cfp_pkg::ARG_INDEX_BITS-1:0]     idx_src;
   logic [cfp_pkg::IDX_ACC_BITS-1:0]       idx_val;
   logic                                   idx_ok;
   logic [cfp_pkg::WIDTH_BITS-1:0]         wid_val;
   logic                                   wid_ok;
   logic                                   comma_ok;
   cfp_pkg::state_type                     space_st;
   cfp_pkg::state_type                     text_st;
   logic                                   is_lb, is_rb, is_sp, is_cm, is_mn, is_cl;

   assign is_lb    = (code_unit == cfp_pkg::CH_LBRACE);
   assign is_rb    = (code_unit == cfp_pkg::CH_RBRACE);
   assign is_sp    = (code_unit == cfp_pkg::CH_SPACE);
   assign is_cm    = (code_unit == cfp_pkg::CH_COMMA);
   assign is_mn    = (code_unit == cfp_pkg::CH_MINUS);
   assign is_cl    = (code_unit == cfp_pkg::CH_COLON);
   assign is_digit = (code_unit >= cfp_pkg::CH_ZERO) && (code_unit <= cfp_pkg::CH_NINE);
   assign digit    = code_unit[3:0];

   // index * 10 + digit; first digit starts from zero
   assign idx_src = (st_ff == cfp_pkg::S_LBRACE) ? '0 : idx_ff;
   assign idx_val = (cfp_pkg::IDX_ACC_BITS'(idx_src) << 3)
                  + (cfp_pkg::IDX_ACC_BITS'(idx_src) << 1)
                  + cfp_pkg::IDX_ACC_BITS'(digit);
   assign idx_ok  = idx_val < cfp_pkg::IDX_ACC_BITS'(arg_count);

   assign wid_val = (wid_ff << 3) + (wid_ff << 1) + cfp_pkg::WIDTH_BITS'(digit);
   assign wid_ok  = wid_ff < cfp_pkg::WIDTH_LIMIT;

   assign comma_ok = (st_ff == cfp_pkg::S_INDEX) || (st_ff == cfp_pkg::S_AFTER_INDEX);
   assign space_st = comma_ok ? cfp_pkg::S_AFTER_INDEX : cfp_pkg::S_AFTER_WIDTH;
   assign text_st  = is_lb ? cfp_pkg::S_LBRACE : (is_rb ? cfp_pkg::S_RBRACE : cfp_pkg::S_LIT);

   // next state and accumulators
   always_comb begin
      st_in    = st_ff;
      idx_in   = idx_ff;
      wid_in   = wid_ff;
      minus_in = minus_ff;
      if (is_end) begin
         st_in    = cfp_pkg::S_LIT;
         idx_in   = '0;
         wid_in   = '0;
         minus_in = 1'b0;
      end else begin
         unique case (st_ff)
            cfp_pkg::S_LIT: begin
               st_in = text_st;
            end
            cfp_pkg::S_LBRACE, cfp_pkg::S_INDEX: begin
               if (st_ff == cfp_pkg::S_LBRACE && is_lb) begin
                  st_in = cfp_pkg::S_LIT;
               end else if (is_digit && idx_ok) begin
                  idx_in = idx_val[cfp_pkg::ARG_INDEX_BITS-1:0];
                  if (st_ff == cfp_pkg::S_LBRACE) begin
                     wid_in   = '0;
                     minus_in = 1'b0;
                  end
                  st_in = cfp_pkg::S_INDEX;
               end else if (is_digit || st_ff == cfp_pkg::S_LBRACE) begin
                  st_in    = cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end else if (is_sp) begin
                  st_in = space_st;
               end else if (is_cm) begin
                  st_in = cfp_pkg::S_WIDTH_START;
               end else if (is_cl) begin
                  st_in = cfp_pkg::S_SPEC;
               end else begin
                  st_in    = is_rb ? cfp_pkg::S_LIT : cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_RBRACE: begin
               if (is_rb) begin
                  st_in = cfp_pkg::S_LIT;
               end else begin
                  st_in    = cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_AFTER_INDEX, cfp_pkg::S_WIDTH, cfp_pkg::S_AFTER_WIDTH: begin
               if (st_ff == cfp_pkg::S_WIDTH && is_digit) begin
                  if (wid_ok) begin
                     wid_in = wid_val;
                  end else begin
                     st_in    = cfp_pkg::S_ERROR;
                     idx_in   = '0;
                     wid_in   = '0;
                     minus_in = 1'b0;
                  end
               end else if (is_sp) begin
                  st_in = space_st;
               end else if (is_cm && comma_ok) begin
                  st_in = cfp_pkg::S_WIDTH_START;
               end else if (is_cl) begin
                  st_in = cfp_pkg::S_SPEC;
               end else begin
                  st_in    = is_rb ? cfp_pkg::S_LIT : cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_WIDTH_START, cfp_pkg::S_WIDTH_MINUS: begin
               if (is_digit) begin
                  wid_in = cfp_pkg::WIDTH_BITS'(digit);
                  st_in  = cfp_pkg::S_WIDTH;
               end else if (st_ff == cfp_pkg::S_WIDTH_START && is_sp) begin
                  st_in = cfp_pkg::S_WIDTH_START;
               end else if (st_ff == cfp_pkg::S_WIDTH_START && is_mn) begin
                  minus_in = 1'b1;
                  st_in    = cfp_pkg::S_WIDTH_MINUS;
               end else begin
                  st_in    = cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_SPEC: begin
               if (is_lb) begin
                  st_in = cfp_pkg::S_SPEC_LBRACE;
               end else if (is_rb) begin
                  st_in = cfp_pkg::S_SPEC_RBRACE;
               end
            end
            cfp_pkg::S_SPEC_LBRACE: begin
               if (is_lb) begin
                  st_in = cfp_pkg::S_SPEC;
               end else begin
                  st_in    = cfp_pkg::S_ERROR;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_SPEC_RBRACE: begin
               if (is_rb) begin
                  st_in = cfp_pkg::S_SPEC;
               end else begin
                  // descriptor closes, this unit is handled as in text state
                  st_in    = text_st;
                  idx_in   = '0;
                  wid_in   = '0;
                  minus_in = 1'b0;
               end
            end
            cfp_pkg::S_ERROR: begin
               st_in = cfp_pkg::S_ERROR;
            end
            default: begin
               st_in    = cfp_pkg::S_LIT;
               idx_in   = '0;
               wid_in   = '0;
               minus_in = 1'b0;
            end
         endcase
      end
   end

   // results of the current item
   always_comb begin
      step    = '0;
      if (is_end) begin
         unique case (st_ff)
            cfp_pkg::S_LIT: begin
               step.n  = 2'd1;
               step.r0 = cfp_pkg::mk_char(cfp_pkg::K_DONE, '0);
            end
            cfp_pkg::S_SPEC_RBRACE: begin
               step.n  = 2'd2;
               step.r0 = cfp_pkg::mk_field(idx_ff, wid_ff, minus_ff);
               step.r1 = cfp_pkg::mk_char(cfp_pkg::K_DONE, '0);
            end
            cfp_pkg::S_ERROR: begin
               step.n = 2'd0;
            end
            default: begin
               step.n  = 2'd1;
               step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
            end
         endcase
      end else begin
         unique case (st_ff)
            cfp_pkg::S_LIT: begin
               if (!is_lb && !is_rb) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_LIT, code_unit);
               end
            end
            cfp_pkg::S_LBRACE: begin
               if (is_lb) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_LIT, code_unit);
               end else if (!(is_digit && idx_ok)) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
               end
            end
            cfp_pkg::S_RBRACE: begin
               step.n  = 2'd1;
               step.r0 = is_rb ? cfp_pkg::mk_char(cfp_pkg::K_LIT, code_unit)
                               : cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
            end
            cfp_pkg::S_INDEX, cfp_pkg::S_AFTER_INDEX,
            cfp_pkg::S_WIDTH, cfp_pkg::S_AFTER_WIDTH: begin
               if (st_ff == cfp_pkg::S_INDEX && is_digit) begin
                  if (!idx_ok) begin
                     step.n  = 2'd1;
                     step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
                  end
               end else if (st_ff == cfp_pkg::S_WIDTH && is_digit) begin
                  if (!wid_ok) begin
                     step.n  = 2'd1;
                     step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
                  end
               end else if (is_sp || (is_cm && comma_ok) || is_cl) begin
                  step.n = 2'd0;
               end else if (is_rb) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_field(idx_ff, wid_ff, minus_ff);
               end else begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
               end
            end
            cfp_pkg::S_WIDTH_START: begin
               if (!is_digit && !is_sp && !is_mn) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
               end
            end
            cfp_pkg::S_WIDTH_MINUS: begin
               if (!is_digit) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
               end
            end
            cfp_pkg::S_SPEC: begin
               if (!is_lb && !is_rb) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_SPEC, code_unit);
               end
            end
            cfp_pkg::S_SPEC_LBRACE: begin
               step.n  = 2'd1;
               step.r0 = is_lb ? cfp_pkg::mk_char(cfp_pkg::K_SPEC, code_unit)
                               : cfp_pkg::mk_char(cfp_pkg::K_ERROR, '0);
            end
            cfp_pkg::S_SPEC_RBRACE: begin
               if (is_rb) begin
                  step.n  = 2'd1;
                  step.r0 = cfp_pkg::mk_char(cfp_pkg::K_SPEC, code_unit);
               end else begin
                  step.n  = (is_lb) ? 2'd1 : 2'd2;
                  step.r0 = cfp_pkg::mk_field(idx_ff, wid_ff, minus_ff);
                  step.r1 = cfp_pkg::mk_char(cfp_pkg::K_LIT, code_unit);
               end
            end
            default: begin
               step.n = 2'd0;
            end
         endcase
      end
      if (step.n == 2'd1) begin
         step.r0.last = 1'b1;
      end
      if (step.n == 2'd2) begin
         step.r1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= cfp_pkg::S_LIT;
         idx_ff   <= '0;
         wid_ff   <= '0;
         minus_ff <= 1'b0;
      end else if (fire) begin
         st_ff    <= st_in;
         idx_ff   <= idx_in;
         wid_ff   <= wid_in;
         minus_ff <= minus_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_result_fifo.sv =====
// Result queue: takes up to two records per cycle, hands out one.
// Depends on cfp_pkg.
`default_nettype none

module cfp_result_fifo (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] push_n,
   input  cfp_pkg::result_type push0,
   input  cfp_pkg::result_type push1,
   input  wire logic       pop,
   output cfp_pkg::result_type head,
   output logic            not_empty,
   output logic            room
);

   cfp_pkg::result_type                  mem_ff [cfp_pkg::FIFO_DEPTH];
   logic [cfp_pkg::FIFO_PTR_BITS-1:0]    wr_ff, wr_in;
   logic [cfp_pkg::FIFO_PTR_BITS-1:0]    rd_ff, rd_in;
   logic [cfp_pkg::FIFO_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [cfp_pkg::FIFO_PTR_BITS-1:0]    wr_next;

   assign wr_next   = wr_ff + 1'b1;
   assign head      = mem_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   // two free slots needed before the parser may take an item
   assign room      = cnt_ff <= cfp_pkg::FIFO_CNT_BITS'(cfp_pkg::FIFO_DEPTH - 2);

   always_comb begin
      wr_in  = wr_ff + cfp_pkg::FIFO_PTR_BITS'(push_n);
      rd_in  = rd_ff + cfp_pkg::FIFO_PTR_BITS'(pop);
      cnt_in = cnt_ff + cfp_pkg::FIFO_CNT_BITS'(push_n) - cfp_pkg::FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/composite_format_parser.sv =====
// Top level of the composite format string parser.
// Depends on cfp_pkg, cfp_parse and cfp_result_fifo.
//
// Usage:
//  - req channel: one UTF-16 code unit per item in req_tdata[15:0]; an item
//    with req_tlast high closes the format string and its data is ignored.
//  - rsp channel: literal chars, spec chars, field descriptors, done and
//    error records. rsp_tuser holds the record kind, rsp_tlast marks the
//    last record caused by one input item (an item gives zero to two).
//  - csr port: csr_wr_en writes arg_count; write it only while idle.
//  - Path: an accepted item lands in the input register, is parsed from
//    there straight into a four-entry result queue once that queue has
//    room, and its records leave on rsp from the head of the queue.
//  - Throughput: one item per cycle while items give at most one record
//    each and rsp_tready stays high; the rsp port moves one record per
//    cycle, so items giving two records hold the input back. The parser
//    takes an item only while the result queue has two free entries.
//  - Stall: when rsp_tready stays low the queue fills, the input register
//    holds and req_tready drops; nothing is lost.
//  - Reset: parser back in text state with cleared field accumulators,
//    arg_count zero, input register and result queue empty.
`default_nettype none

module composite_format_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,   // arg_count
   // req
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,     // [15:0] code_unit
   input  wire logic        req_tlast,     // is_end
   // rsp
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,     // [15:0] char_out, [23:16] arg_index,
                                           // [47:24] field_width, [48] left_justify,
                                           // [55:49] zero
   output logic [2:0]       rsp_tuser,     // kind
   output logic             rsp_tlast      // last
);

   logic [cfp_pkg::ARG_INDEX_BITS-1:0] arg_count_ff;

   // input register
   logic                               in_vld_ff;
   logic [cfp_pkg::CHAR_BITS-1:0]      in_code_ff;
   logic                               in_end_ff;

   cfp_pkg::step_type                  step;
   cfp_pkg::result_type                head;
   logic                               room;
   logic                               not_empty;
   logic                               fire;
   logic                               req_acc;
   logic                               pop;

   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;
   assign req_acc    = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_count_ff <= '0;
      end else if (csr_wr_en) begin
         arg_count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_acc) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_code_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   cfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .code_unit (in_code_ff),
      .is_end    (in_end_ff),
      .arg_count (arg_count_ff),
      .step      (step)
   );

   cfp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (fire ? step.n : 2'd0),
      .push0     (step.r0),
      .push1     (step.r1),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {7'd0, head.left_justify, head.field_width,
                        head.arg_index, head.char_out};

endmodule

`default_nettype wire

// ===== hw/rtl/cfp_checker.sv =====
// Port-level checks for composite_format_parser, attached by bind.
// Depends on cfp_pkg.
`default_nettype none

module cfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled record holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp record changed while stalled");

   // queue and input register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("rsp valid or req stalled after reset");

   // only descriptors carry index, width and justify
   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cfp_pkg::K_FIELD |-> rsp_tdata[55:16] == '0)
      else $error("descriptor fields set on non-descriptor record");

   // only literal and spec records carry a code unit
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cfp_pkg::K_LIT && rsp_tuser != cfp_pkg::K_SPEC
      |-> rsp_tdata[15:0] == '0)
      else $error("code unit set on non-character record");

   // done closes the results of its end item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == cfp_pkg::K_DONE |-> rsp_tlast)
      else $error("done record without last");

endmodule

bind composite_format_parser cfp_checker u_cfp_checker (.*);

`default_nettype wire
